>>> hdl/process_scheduler_tick_unit_macros.svh
// ----------------------------------------------------------------------------
// Scheduler tick unit assertion macros
// Shared assertion forms for the scheduler tick unit.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SCHEDULER_TICK_UNIT_MACROS_SVH
`define PROCESS_SCHEDULER_TICK_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PST_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pst assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PST_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pst assertion failed");

`endif

>>> hdl/pst_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler tick package
// Policy codes, operation codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package pst_pkg;

	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_RR   = 2'd1,
		POL_SJF  = 2'd2,
		POL_PSJF = 2'd3
	} policy_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] REG_POLICY    = 2'd0;
	localparam logic [1:0] REG_JOB_COUNT = 2'd1;
	localparam logic [1:0] REG_QUANTUM   = 2'd2;

	localparam int CFG_DATA_W = 16;
	localparam int RUN_W      = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RETIRE,
		ST_SCAN,
		ST_DECIDE,
		ST_DEC_RD,
		ST_DEC_WR,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

>>> hdl/pst_stream_if.sv
// ----------------------------------------------------------------------------
// Scheduler tick stream interface
// Valid/ready channel with a payload of parametric type.
// ----------------------------------------------------------------------------
`default_nettype none
interface pst_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/process_scheduler_tick_unit.sv
// Scheduler tick unit: a load is written to the job memories when it transfers. A tick's
// report is offered once the scan of the slots in use and the bit-serial remainder of
// elapsed ticks over the quantum have both finished, then the decide and update states
// run; the next item is taken only after the report has been accepted.
// Reset (arst_n low) clears ready flags, current job, tick count, done count
// and registers; the job memories are not cleared and must be loaded.
`default_nettype none
`include "process_scheduler_tick_unit_macros.svh"
// ----------------------------------------------------------------------------
// Scheduler tick unit
// Job table in memory, per-tick retire, arrival marking, policy scan, update.
// ----------------------------------------------------------------------------
module process_scheduler_tick_unit
	import pst_pkg::*;
#(
	parameter int MAX_JOBS  = 16,
	parameter int TIME_BITS = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire  [1:0]             cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data,
	pst_stream_if.sink             in_ch,
	pst_stream_if.source           out_ch
);
	localparam int IW  = $clog2(MAX_JOBS);
	localparam int CW  = $clog2(MAX_JOBS + 1);
	localparam int DCW = $clog2(TIME_BITS + 1);

	// configuration registers
	logic [1:0]  policy_q;
	logic [4:0]  job_count_q;
	logic [15:0] quantum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_FIFO;
			job_count_q <= 5'd1;
			quantum_q   <= 16'd500;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY:    policy_q    <= cfg_data[1:0];
				REG_JOB_COUNT: job_count_q <= cfg_data[4:0];
				REG_QUANTUM:   quantum_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// slots in use, clamped
	logic [CW-1:0] n_c;
	always_comb begin
		if (CW > 5) n_c = CW'(job_count_q);
		else if (32'(job_count_q) > MAX_JOBS) n_c = CW'(MAX_JOBS);
		else n_c = CW'(job_count_q);
	end

	// job memories
	logic [TIME_BITS-1:0] arr_mem [MAX_JOBS];
	logic [RUN_W-1:0]     rem_mem [MAX_JOBS];
	logic [IW-1:0]        rd_addr;
	logic [TIME_BITS-1:0] arr_rd_q;
	logic [RUN_W-1:0]     rem_rd_q;
	logic                 mem_we;
	logic [IW-1:0]        wr_addr;
	logic [TIME_BITS-1:0] arr_wd;
	logic [RUN_W-1:0]     rem_wd;
	logic                 arr_we;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rem_mem[wr_addr] <= rem_wd;
			if (arr_we) arr_mem[wr_addr] <= arr_wd;
		end
		arr_rd_q <= arr_mem[rd_addr];
		rem_rd_q <= rem_mem[rd_addr];
	end

	// state
	state_t state_q, state_d;
	logic [MAX_JOBS-1:0]  ready_q;
	logic [IW-1:0]        cur_q;
	logic                 cur_v_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [TIME_BITS-1:0] last_sw_q;
	logic [CW-1:0]        done_q;
	logic [CW:0]          cnt_q;     // scan address issued
	logic                 rd_v_q;    // read data valid for slot rd_slot_q
	logic [IW-1:0]        rd_slot_q;
	logic                 pick_v_q;
	logic [IW-1:0]        pick_q;
	logic [TIME_BITS-1:0] pick_arr_q;
	logic [RUN_W-1:0]     pick_rem_q;
	logic [CW-1:0]        rr_s_q;    // first slot of the rotation order
	logic                 rr_v_q;    // first eligible at or after the rotation start
	logic [IW-1:0]        rr_q;
	logic                 rr_w_v_q;  // first eligible before the rotation start
	logic [IW-1:0]        rr_w_q;
	logic [TIME_BITS-1:0] div_dvd_q; // elapsed ticks, shifted out msb first
	logic [15:0]          div_rem_q;
	logic [DCW-1:0]       div_cnt_q;
	logic                 cur_zero_q;
	logic                 fin_v_q;
	logic [IW-1:0]        fin_i_q;
	logic                 sw_q;
	logic                 out_v_q;
	logic                 is_tick;
	logic                 retire_c;

	assign is_tick = in_ch.data.operation == OP_TICK;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_v_q;
	assign retire_c = done_q < n_c && cur_v_q && rem_rd_q == '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready && is_tick) state_d = ST_RETIRE;
			ST_RETIRE: state_d = ST_SCAN;
			ST_SCAN: if (!rd_v_q && cnt_q >= (CW+1)'(n_c) && div_cnt_q == '0)
				state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_DEC_RD;
			ST_DEC_RD: state_d = ST_DEC_WR;
			ST_DEC_WR: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory read address and write controls
	always_comb begin
		rd_addr = cur_q;
		if (state_q == ST_SCAN) rd_addr = cnt_q[IW-1:0];
		mem_we  = 1'b0;
		arr_we  = 1'b0;
		wr_addr = cur_q;
		arr_wd  = TIME_BITS'(in_ch.data.arrival_time);
		rem_wd  = rem_rd_q - RUN_W'(1);
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready && !is_tick
			&& 32'(in_ch.data.entry_index) < MAX_JOBS) begin
			mem_we  = 1'b1;
			arr_we  = 1'b1;
			wr_addr = IW'(in_ch.data.entry_index);
			rem_wd  = in_ch.data.run_time;
		end else if (state_q == ST_DEC_WR && !cur_zero_q && cur_v_q && rem_rd_q != '0) begin
			mem_we = 1'b1;
		end
	end

	// (cur + 1) mod n by compare and subtract
	function automatic logic [CW-1:0] wrap_next(input logic [IW-1:0] cur,
			input logic [CW-1:0] n);
		logic [2*CW:0] r;
		logic [2*CW:0] d;
		r = (2*CW+1)'(cur) + (2*CW+1)'(1);
		for (int b = CW; b >= 0; b--) begin
			d = (2*CW+1)'(n) << b;
			if (n != '0 && r >= d) r = r - d;
		end
		return r[CW-1:0];
	endfunction

	// scan slot eligibility, using the ready flag updated with this tick's arrival
	logic elig_c, rdy_c, earlier_c;
	logic [15:0] q_c;
	logic [16:0] div_sh_c;
	logic [16:0] div_nxt_c;
	logic rot_c;
	logic [IW-1:0] next_c;
	logic next_v_c;
	always_comb begin
		rdy_c  = ready_q[rd_slot_q] || (arr_rd_q == tick_q);
		elig_c = rdy_c && rem_rd_q != '0;
		case (policy_q)
			POL_FIFO:           earlier_c = arr_rd_q < pick_arr_q;
			POL_SJF, POL_PSJF:  earlier_c = rem_rd_q < pick_rem_q;
			default:            earlier_c = 1'b0;
		endcase
		q_c = (quantum_q == '0) ? 16'd1 : quantum_q;
		div_sh_c = {div_rem_q, div_dvd_q[TIME_BITS-1]};
		div_nxt_c = (div_sh_c >= {1'b0, q_c}) ? (div_sh_c - {1'b0, q_c}) : div_sh_c;
		rot_c = div_rem_q == '0;
		next_v_c = 1'b0;
		next_c = cur_q;
		if (cur_v_q && (policy_q == POL_FIFO || policy_q == POL_SJF)) begin
			next_v_c = 1'b1;
		end else if (policy_q == POL_RR) begin
			if (!cur_v_q) begin
				next_v_c = pick_v_q;
				next_c = pick_q;
			end else begin
				next_v_c = 1'b1;
				if (rot_c) begin
					if (rr_v_q) next_c = rr_q;
					else if (rr_w_v_q) next_c = rr_w_q;
				end
			end
		end else begin
			next_v_c = pick_v_q;
			next_c = pick_q;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= '0;
			cur_q <= '0;
			cur_v_q <= 1'b0;
			tick_q <= '0;
			last_sw_q <= '0;
			done_q <= '0;
			cnt_q <= '0;
			rd_v_q <= 1'b0;
			rd_slot_q <= '0;
			pick_v_q <= 1'b0;
			pick_q <= '0;
			pick_arr_q <= '0;
			pick_rem_q <= '0;
			rr_s_q <= '0;
			rr_v_q <= 1'b0;
			rr_q <= '0;
			rr_w_v_q <= 1'b0;
			rr_w_q <= '0;
			div_dvd_q <= '0;
			div_rem_q <= '0;
			div_cnt_q <= '0;
			fin_v_q <= 1'b0;
			fin_i_q <= '0;
			sw_q <= 1'b0;
			out_v_q <= 1'b0;
			cur_zero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (!is_tick) begin
							if (32'(in_ch.data.entry_index) < MAX_JOBS)
								ready_q[IW'(in_ch.data.entry_index)] <= 1'b0;
						end
						fin_v_q <= 1'b0;
						sw_q <= 1'b0;
					end
				end
				ST_RETIRE: begin
					// rem_rd_q holds current job's remaining time
					cnt_q <= '0;
					rd_v_q <= 1'b0;
					pick_v_q <= 1'b0;
					rr_v_q <= 1'b0;
					rr_w_v_q <= 1'b0;
					rr_s_q <= wrap_next(cur_q, n_c);
					// start the remainder of elapsed ticks over the quantum
					div_dvd_q <= tick_q - last_sw_q;
					div_rem_q <= '0;
					div_cnt_q <= DCW'(TIME_BITS);
					cur_zero_q <= (done_q >= n_c) || (retire_c && done_q + CW'(1) >= n_c);
					if (retire_c) begin
						fin_v_q <= 1'b1;
						fin_i_q <= cur_q;
						cur_v_q <= 1'b0;
						done_q <= done_q + CW'(1);
					end
				end
				ST_SCAN: begin
					// advance the remainder one dividend bit
					if (div_cnt_q != '0) begin
						div_rem_q <= div_nxt_c[15:0];
						div_dvd_q <= {div_dvd_q[TIME_BITS-2:0], 1'b0};
						div_cnt_q <= div_cnt_q - DCW'(1);
					end
					if (cur_zero_q) begin
						cnt_q <= (CW+1)'(n_c);
						rd_v_q <= 1'b0;
					end else begin
						if (cnt_q < (CW+1)'(n_c)) begin
							cnt_q <= cnt_q + (CW+1)'(1);
							rd_slot_q <= cnt_q[IW-1:0];
							rd_v_q <= 1'b1;
						end else begin
							rd_v_q <= 1'b0;
						end
						if (rd_v_q) begin
							if (rdy_c) ready_q[rd_slot_q] <= 1'b1;
							if (elig_c) begin
								if (!pick_v_q || earlier_c) begin
									pick_v_q <= 1'b1;
									pick_q <= rd_slot_q;
									pick_arr_q <= arr_rd_q;
									pick_rem_q <= rem_rd_q;
								end
								if (CW'(rd_slot_q) >= rr_s_q && !rr_v_q) begin
									rr_v_q <= 1'b1;
									rr_q <= rd_slot_q;
								end
								if (CW'(rd_slot_q) < rr_s_q && !rr_w_v_q) begin
									rr_w_v_q <= 1'b1;
									rr_w_q <= rd_slot_q;
								end
							end
						end
					end
				end
				ST_DECIDE: begin
					if (!cur_zero_q) begin
						if (next_v_c && (!cur_v_q || cur_q != next_c)) begin
							cur_q <= next_c;
							cur_v_q <= 1'b1;
							last_sw_q <= tick_q;
							sw_q <= 1'b1;
						end
						tick_q <= tick_q + TIME_BITS'(1);
					end
				end
				ST_DEC_RD: ;
				ST_DEC_WR: ;
				ST_OUT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// result outputs, driven from registers
	always_comb begin
		out_ch.valid = out_v_q;
		out_ch.data.running_valid  = cur_v_q;
		out_ch.data.running_index  = cur_v_q ? 4'(cur_q) : 4'd0;
		out_ch.data.finished_valid = fin_v_q;
		out_ch.data.finished_index = fin_v_q ? 4'(fin_i_q) : 4'd0;
		out_ch.data.switched       = sw_q;
		out_ch.data.all_done       = done_q >= n_c;
	end

	// memory write of a decrement only happens when cur_zero_q is clear
	`PST_ASSERT_IMP(a_dec_live, clk, arst_n, state_q == ST_DEC_WR && mem_we, !cur_zero_q || !cur_v_q)
	`PST_ASSERT_IMP(a_no_take_busy, clk, arst_n, in_ch.valid && in_ch.ready, state_q == ST_IDLE)
	`PST_ASSERT_NEXT(a_out_after, clk, arst_n, state_q == ST_OUT, out_v_q)
	`PST_ASSERT_IMP(a_div_done, clk, arst_n, state_q == ST_DECIDE, div_cnt_q == '0)
endmodule
`default_nettype wire
